// File: rtl/cec_pkg.sv
// ----------------------------------------------------------------------------
// cec_pkg
// Shared constants and types of the cache event counter unit.
// ----------------------------------------------------------------------------
package cec_pkg;

    localparam int EVENT_COUNTERS  = 8;
    localparam int NUM_EVENT_CODES = 21;

    localparam int OP_W     = 2;
    localparam int OFFSET_W = 9;
    localparam int DATA_W   = 32;
    localparam int MASK_W   = 21;
    localparam int CODE_W   = 8;

    localparam int CNT_IDX_W  = (EVENT_COUNTERS > 1) ? $clog2(EVENT_COUNTERS) : 1;
    localparam int MASK_IDX_W = $clog2(MASK_W);
    localparam int CODE_LIMIT = (NUM_EVENT_CODES < MASK_W) ? NUM_EVENT_CODES : MASK_W;
    localparam int SLOT_COUNT = 8;
    localparam int SEL_PER_WORD = 4;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    localparam logic [OFFSET_W-1:0] CTRL_OFFSET      = 9'h004;
    localparam logic [OFFSET_W-1:0] SELECT_LO_OFFSET = 9'h140;
    localparam logic [OFFSET_W-1:0] SELECT_HI_OFFSET = 9'h144;
    localparam logic [OFFSET_W-1:0] COUNT_OFFSET     = 9'h170;

    localparam int                COUNT_ENABLE_BIT = 24;
    localparam logic [CODE_W-1:0] NO_EVENT         = 8'hff;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [OFFSET_W-1:0] byte_offset;
        logic [DATA_W-1:0]   write_data;
        logic [MASK_W-1:0]   event_mask;
    } item_t;

endpackage

// File: rtl/cec_if.sv
// ----------------------------------------------------------------------------
// cec_if
// Valid/ready channels of the cache event counter unit.
// ----------------------------------------------------------------------------
interface cec_item_if;
    logic                          valid;
    logic                          ready;
    logic [cec_pkg::OP_W-1:0]      op;
    logic [cec_pkg::OFFSET_W-1:0]  byte_offset;
    logic [cec_pkg::DATA_W-1:0]    write_data;
    logic [cec_pkg::MASK_W-1:0]    event_mask;

    modport source (output valid, output op, output byte_offset, output write_data,
                    output event_mask, input ready);
    modport sink   (input valid, input op, input byte_offset, input write_data,
                    input event_mask, output ready);
endinterface

interface cec_result_if;
    logic                        valid;
    logic                        ready;
    logic [cec_pkg::DATA_W-1:0]  read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

// File: rtl/cec_regfile.sv
// ----------------------------------------------------------------------------
// cec_regfile
// Control, event-select and counter registers with read decode and tick logic.
// ----------------------------------------------------------------------------
module cec_regfile
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         exec,
    input  cec_pkg::item_t               item,
    output logic [cec_pkg::DATA_W-1:0]   read_data
);

    logic [cec_pkg::DATA_W-1:0] control_reg;
    logic [cec_pkg::CODE_W-1:0] select_reg [cec_pkg::EVENT_COUNTERS];
    logic [cec_pkg::DATA_W-1:0] count_reg  [cec_pkg::EVENT_COUNTERS];

    logic [cec_pkg::CODE_W-1:0] slot_code  [cec_pkg::SLOT_COUNT];
    logic [cec_pkg::OFFSET_W-1:0] off;
    logic [cec_pkg::OFFSET_W-1:0] count_diff;
    logic [cec_pkg::OFFSET_W-3:0] count_word;
    logic [cec_pkg::CNT_IDX_W-1:0] count_idx;
    logic                         count_hit;
    logic                         is_read;
    logic                         is_write;
    logic                         is_tick;
    logic                         count_en;
    logic [cec_pkg::DATA_W-1:0]   select_lo_word;
    logic [cec_pkg::DATA_W-1:0]   select_hi_word;
    logic [cec_pkg::DATA_W-1:0]   reg_value;
    logic [cec_pkg::EVENT_COUNTERS-1:0] event_hit;

    assign off        = {item.byte_offset[cec_pkg::OFFSET_W-1:2], 2'b00};
    assign count_diff = off - cec_pkg::COUNT_OFFSET;
    assign count_word = count_diff[cec_pkg::OFFSET_W-1:2];
    assign count_idx  = count_word[cec_pkg::CNT_IDX_W-1:0];
    assign count_hit  = (off >= cec_pkg::COUNT_OFFSET)
                      && (count_word < (cec_pkg::OFFSET_W-2)'(cec_pkg::EVENT_COUNTERS));

    assign is_read  = exec && (item.op == cec_pkg::OP_READ);
    assign is_write = exec && (item.op == cec_pkg::OP_WRITE);
    assign is_tick  = exec && (item.op == cec_pkg::OP_TICK);
    assign count_en = control_reg[cec_pkg::COUNT_ENABLE_BIT];

    for (genvar s = 0; s < cec_pkg::SLOT_COUNT; s++)
    begin : g_slot
        if (s < cec_pkg::EVENT_COUNTERS)
        begin : g_present
            assign slot_code[s] = select_reg[s];
        end
        else
        begin : g_absent
            assign slot_code[s] = cec_pkg::NO_EVENT;
        end
    end

    assign select_lo_word = {slot_code[3], slot_code[2], slot_code[1], slot_code[0]};
    assign select_hi_word = {slot_code[7], slot_code[6], slot_code[5], slot_code[4]};

    always_comb
    begin
        reg_value = '0;
        if (off == cec_pkg::CTRL_OFFSET)
        begin
            reg_value = control_reg;
        end
        else if (off == cec_pkg::SELECT_LO_OFFSET)
        begin
            reg_value = select_lo_word;
        end
        else if (off == cec_pkg::SELECT_HI_OFFSET)
        begin
            reg_value = select_hi_word;
        end
        else if (count_hit)
        begin
            reg_value = count_reg[count_idx];
        end
    end

    assign read_data = is_read ? reg_value : '0;

    always_comb
    begin
        for (int i = 0; i < cec_pkg::EVENT_COUNTERS; i++)
        begin
            event_hit[i] = (select_reg[i] < cec_pkg::CODE_W'(cec_pkg::CODE_LIMIT))
                && item.event_mask[select_reg[i][cec_pkg::MASK_IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg <= '0;
            for (int i = 0; i < cec_pkg::EVENT_COUNTERS; i++)
            begin
                select_reg[i] <= cec_pkg::NO_EVENT;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            if (is_write && (off == cec_pkg::CTRL_OFFSET))
            begin
                control_reg <= item.write_data;
            end
            for (int i = 0; i < cec_pkg::EVENT_COUNTERS; i++)
            begin
                if (is_write && (((i >> 2) == 0) ? (off == cec_pkg::SELECT_LO_OFFSET)
                                                 : (off == cec_pkg::SELECT_HI_OFFSET)))
                begin
                    select_reg[i] <= item.write_data[8 * (i & 3) +: cec_pkg::CODE_W];
                end
                if (is_write && count_hit && (count_idx == cec_pkg::CNT_IDX_W'(i)))
                begin
                    count_reg[i] <= item.write_data;
                end
                else if (is_tick && count_en && event_hit[i])
                begin
                    count_reg[i] <= count_reg[i] + 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/cache_event_counter_unit.sv
// ----------------------------------------------------------------------------
// cache_event_counter_unit
// Cache performance monitor: eight event counters behind a register map.
// ----------------------------------------------------------------------------
// Path: each item passes through the input register, then the result register;
// the register file is read and updated as the item leaves the input register.
// Throughput: one item per cycle, sustained while the result side takes words.
// Reset: counting disabled, event selects 0xff, counters zero, pipeline empty.
// ----------------------------------------------------------------------------
module cache_event_counter_unit
(
    input  logic                clk,
    input  logic                rst_n,
    cec_item_if.sink            item,
    cec_result_if.source        result
);

    cec_pkg::item_t             item_reg;
    logic                       item_valid_reg;
    logic                       item_valid_next;
    logic [cec_pkg::DATA_W-1:0] read_data_reg;
    logic                       result_valid_reg;
    logic                       result_valid_next;
    logic [cec_pkg::DATA_W-1:0] read_data_comb;
    logic                       advance;
    logic                       take;

    assign advance = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign take = item.valid && item.ready;

    assign item_valid_next   = take || (item_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && !result.ready);

    cec_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .exec      (advance),
        .item      (item_reg),
        .read_data (read_data_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op          <= item.op;
            item_reg.byte_offset <= item.byte_offset;
            item_reg.write_data  <= item.write_data;
            item_reg.event_mask  <= item.event_mask;
        end
        if (advance)
        begin
            read_data_reg <= read_data_comb;
        end
    end

    assign result.valid     = result_valid_reg;
    assign result.read_data = read_data_reg;

endmodule
